@@ hdl/cntc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked numeric type cast package
// Type tags, status codes and the payload types shared by the block.
// ----------------------------------------------------------------------------
package cntc_pkg;
	localparam logic [2:0] TAG_NULL  = 3'd0;
	localparam logic [2:0] TAG_S64   = 3'd1;
	localparam logic [2:0] TAG_U64   = 3'd2;
	localparam logic [2:0] TAG_DBL   = 3'd3;
	localparam logic [2:0] TAG_OTHER = 3'd4;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_INEXACT     = 2'd1;
	localparam logic [1:0] ST_OVER_MAX    = 2'd2;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

	typedef struct packed {
		logic [2:0]  source_type;
		logic [63:0] source_bits;
		logic [2:0]  target_type;
	} cast_in_t;

	typedef struct packed {
		logic [2:0]  result_type;
		logic [63:0] result_bits;
		logic [1:0]  cast_status;
	} cast_out_t;
endpackage

@@ hdl/cntc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cast channel interfaces
// Valid/ready channels for input and result items.
// ----------------------------------------------------------------------------
interface cntc_in_if;
	logic               valid;
	logic               ready;
	cntc_pkg::cast_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface cntc_out_if;
	logic                valid;
	logic                ready;
	cntc_pkg::cast_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ hdl/checked_numeric_type_cast.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked numeric type cast
// Converts a typed 64-bit value between signed, unsigned and double forms
// and reports a status: exact, inexact, over the maximum or unsupported.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// in_ch     sink       source_type, source_bits, target_type
// out_ch    source     result_type, result_bits, cast_status
//
// One item per cycle while the output is not stalled; an item passes stages 1 to 4 in order.
// Stage 1 decodes the pair and takes the integer magnitude, stage 2 counts
// leading zeros, stage 3 normalizes, unpacks the double and checks, stage 4 packs.
// Reset clears the valid bits only. A stall at the output holds every stage
// whose successor is full; nothing is lost or repeated.
module checked_numeric_type_cast (
	input logic clk,
	input logic arst_n,
	cntc_in_if.sink in_ch,
	cntc_out_if.source out_ch
);
	import cntc_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || out_ch.ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_ch.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Operation classes decided in stage 1.
	localparam logic [2:0] OP_PASS = 3'd0;
	localparam logic [2:0] OP_FAIL = 3'd1;
	localparam logic [2:0] OP_I2D  = 3'd2;
	localparam logic [2:0] OP_D2I  = 3'd3;
	localparam logic [2:0] OP_U2S  = 3'd4;

	cast_in_t pin;
	logic [2:0] op_c;
	logic [1:0] fst_c;
	logic       neg_c;
	logic [63:0] mag_c;

	assign pin = in_ch.payload;

	always_comb begin
		op_c = OP_FAIL;
		fst_c = ST_UNSUPPORTED;
		if (pin.source_type > TAG_OTHER || pin.target_type > TAG_OTHER) begin
			op_c = OP_FAIL;
		end else if (pin.source_type == pin.target_type || pin.source_type == TAG_NULL) begin
			op_c = OP_PASS;
		end else if (pin.source_type == TAG_S64 && pin.target_type == TAG_U64) begin
			op_c = OP_PASS;
		end else if (pin.source_type == TAG_U64 && pin.target_type == TAG_S64) begin
			op_c = OP_U2S;
		end else if ((pin.source_type == TAG_S64 || pin.source_type == TAG_U64)
				&& pin.target_type == TAG_DBL) begin
			op_c = OP_I2D;
		end else if (pin.source_type == TAG_DBL
				&& (pin.target_type == TAG_S64 || pin.target_type == TAG_U64)) begin
			op_c = OP_D2I;
		end
		neg_c = pin.source_type == TAG_S64 && pin.source_bits[63];
		mag_c = neg_c ? (~pin.source_bits + 64'd1) : pin.source_bits;
	end

	// Stage 1 registers.
	cast_in_t    in_s1;
	logic [2:0]  op_s1;
	logic [1:0]  fst_s1;
	logic        neg_s1;
	logic [63:0] mag_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			in_s1 <= pin;
			op_s1 <= op_c;
			fst_s1 <= fst_c;
			neg_s1 <= neg_c;
			mag_s1 <= mag_c;
		end
	end

	// Stage 2: leading zero count of the integer magnitude.
	logic [6:0] lz_c;
	always_comb begin
		lz_c = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (mag_s1[i]) lz_c = 7'(63 - i);
		end
	end

	cast_in_t    in_s2;
	logic [2:0]  op_s2;
	logic [1:0]  fst_s2;
	logic        neg_s2;
	logic [63:0] mag_s2;
	logic [6:0]  lz_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			in_s2 <= in_s1;
			op_s2 <= op_s1;
			fst_s2 <= fst_s1;
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			lz_s2 <= lz_c;
		end
	end

	// Stage 3: normalize integer, shift double mantissa, check exactness.
	logic [63:0] norm_c;
	logic        i2d_ok_c;
	logic [10:0] ex_c;
	logic [52:0] man_c;
	logic [63:0] ival_c;
	logic        d2i_ok_c;
	logic [11:0] sh_c;

	always_comb begin
		norm_c = mag_s2 << lz_s2[5:0];
		// Exact when no bits below the 53 kept bits.
		i2d_ok_c = (norm_c[10:0] == 11'd0);
		ex_c = in_s2.source_bits[62:52];
		man_c = {1'b1, in_s2.source_bits[51:0]};
		ival_c = 64'd0;
		d2i_ok_c = 1'b0;
		sh_c = 12'd0;
		if (ex_c == 11'd0) begin
			d2i_ok_c = (in_s2.source_bits[51:0] == 52'd0);
			ival_c = 64'd0;
		end else if (ex_c >= 11'd1023 && ex_c <= 11'd1023 + 11'd63) begin
			sh_c = {1'b0, ex_c} - 12'd1023;
			if (sh_c >= 12'd52) begin
				ival_c = {11'd0, man_c} << (sh_c[5:0] - 6'd52);
				d2i_ok_c = 1'b1;
			end else begin
				ival_c = {11'd0, man_c} >> (6'd52 - sh_c[5:0]);
				d2i_ok_c = ((man_c << (sh_c[5:0] + 6'd1)) & {53{1'b1}}) == 53'd0;
			end
			if (in_s2.target_type == TAG_S64) begin
				if (in_s2.source_bits[63])
					d2i_ok_c = d2i_ok_c && (sh_c < 12'd63
						|| in_s2.source_bits[51:0] == 52'd0);
				else
					d2i_ok_c = d2i_ok_c && sh_c < 12'd63;
			end else begin
				d2i_ok_c = d2i_ok_c && !in_s2.source_bits[63];
			end
		end
	end

	cast_in_t    in_s3;
	logic [2:0]  op_s3;
	logic [1:0]  fst_s3;
	logic        neg_s3;
	logic [63:0] norm_s3;
	logic [6:0]  lz_s3;
	logic        i2d_ok_s3;
	logic [63:0] ival_s3;
	logic        d2i_ok_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			in_s3 <= in_s2;
			op_s3 <= op_s2;
			fst_s3 <= fst_s2;
			neg_s3 <= neg_s2;
			norm_s3 <= norm_c;
			lz_s3 <= lz_s2;
			i2d_ok_s3 <= i2d_ok_c;
			ival_s3 <= ival_c;
			d2i_ok_s3 <= d2i_ok_c;
		end
	end

	// Stage 4: pack the result and select.
	cast_out_t res_c;
	logic [10:0] bexp_c;
	logic [63:0] dbl_c;

	always_comb begin
		bexp_c = 11'd1086 - {4'd0, lz_s3};
		if (lz_s3 == 7'd64) dbl_c = {neg_s3, 63'd0};
		else dbl_c = {neg_s3, bexp_c, norm_s3[62:11]};
		res_c.result_type = in_s3.source_type;
		res_c.result_bits = in_s3.source_bits;
		res_c.cast_status = fst_s3;
		case (op_s3)
			OP_PASS: begin
				res_c.result_type = (in_s3.source_type == TAG_NULL) ? TAG_NULL
					: in_s3.target_type;
				res_c.cast_status = ST_OK;
			end
			OP_U2S: begin
				if (in_s3.source_bits[63]) begin
					res_c.cast_status = ST_OVER_MAX;
				end else begin
					res_c.result_type = TAG_S64;
					res_c.cast_status = ST_OK;
				end
			end
			OP_I2D: begin
				if (i2d_ok_s3) begin
					res_c.result_type = TAG_DBL;
					res_c.result_bits = dbl_c;
					res_c.cast_status = ST_OK;
				end else begin
					res_c.cast_status = ST_INEXACT;
				end
			end
			OP_D2I: begin
				if (d2i_ok_s3) begin
					res_c.result_type = in_s3.target_type;
					res_c.result_bits = in_s3.source_bits[63] ? (~ival_s3 + 64'd1)
						: ival_s3;
					res_c.cast_status = ST_OK;
				end else begin
					res_c.cast_status = ST_INEXACT;
				end
			end
			default: res_c.cast_status = ST_UNSUPPORTED;
		endcase
	end

	cast_out_t res_s4;
	always_ff @(posedge clk) begin
		if (en4) res_s4 <= res_c;
	end

	assign out_ch.valid = v_s4;
	assign out_ch.payload = res_s4;
endmodule
